FILE: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and fixed field widths of the sliding window minimum unit.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int CFG_BITS = 9;
  localparam int OUT_BITS = 32;

  // controls from the top level to the cell row
  typedef struct packed {
    logic clear;
    logic step;
    logic restart;
  } row_ctrl_t;

  // controls broadcast along the cell row
  typedef struct packed {
    logic clear;
    logic step;
    logic restart;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/swm_if.sv
// ----------------------------------------------------------------------------
// swm channel interfaces
// Valid/ready channels for samples, results and the window length write.
// ----------------------------------------------------------------------------
interface swm_stream_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   restart;

  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

interface swm_result_if ();
  logic                          valid;
  logic                          ready;
  logic [swm_pkg::OUT_BITS-1:0]  window_min;

  modport source (output valid, window_min, input ready);
  modport sink   (input valid, window_min, output ready);
endinterface

interface swm_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [swm_pkg::CFG_BITS-1:0]  window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

FILE: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One queue slot: holds a candidate value and its age, shifts toward the
// front, drops itself when the new sample does not exceed it, or takes the sample.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int VAL_W = 32,
  parameter int AGE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  logic [VAL_W-1:0]    sample,
  input  logic                left_post_valid,
  input  logic                right_valid,
  input  logic [VAL_W-1:0]    right_value,
  input  logic [AGE_W-1:0]    right_age,
  output logic                valid,
  output logic [VAL_W-1:0]    value,
  output logic [AGE_W-1:0]    age,
  output logic                post_valid,
  output logic [VAL_W-1:0]    value_next
);

  logic             sh_valid;
  logic [VAL_W-1:0] sh_value;
  logic [AGE_W-1:0] sh_age;
  logic             load;
  logic             valid_next;
  logic [AGE_W-1:0] age_next;

  assign sh_valid = ctrl.shift ? right_valid : valid;
  assign sh_value = ctrl.shift ? right_value : value;
  assign sh_age   = ctrl.shift ? right_age   : age;

  // entries not below the new sample leave the back of the queue
  assign post_valid = sh_valid && !ctrl.restart && (sh_value < sample);
  // first free slot takes the sample
  assign load       = !post_valid && left_post_valid;

  always_comb begin
    valid_next = valid;
    value_next = value;
    age_next   = age;
    if (ctrl.clear) begin
      valid_next = 1'b0;
    end else if (ctrl.step) begin
      valid_next = post_valid || load;
      if (load) begin
        value_next = sample;
        age_next   = '0;
      end else begin
        value_next = sh_value;
        age_next   = sh_age + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    age   <= age_next;
  end

endmodule

FILE: rtl/swm_row.sv
// ----------------------------------------------------------------------------
// swm_row
// Row of queue cells, front at cell 0; retires the front entry once it has
// aged out of the window.
// ----------------------------------------------------------------------------
module swm_row #(
  parameter int WINDOW_MAX = 256,
  parameter int VAL_W      = 32,
  parameter int LEN_W      = 9,
  parameter int AGE_W      = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  swm_pkg::row_ctrl_t ctrl,
  input  logic [VAL_W-1:0]   sample,
  input  logic [LEN_W-1:0]   len,
  output logic [VAL_W-1:0]   front_next
);

  logic [WINDOW_MAX-1:0] valid_w;
  logic [WINDOW_MAX-1:0] post_w;
  logic [VAL_W-1:0]      value_w [WINDOW_MAX];
  logic [AGE_W-1:0]      age_w   [WINDOW_MAX];
  logic [VAL_W-1:0]      next_w  [WINDOW_MAX];
  swm_pkg::cell_ctrl_t   cell_ctrl;

  always_comb begin
    cell_ctrl.clear   = ctrl.clear;
    cell_ctrl.step    = ctrl.step;
    cell_ctrl.restart = ctrl.restart;
    // front entry is one step from leaving the window
    cell_ctrl.shift   = valid_w[0] && ((LEN_W'(age_w[0]) + LEN_W'(1)) >= len);
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic             left_post;
    logic             right_valid;
    logic [VAL_W-1:0] right_value;
    logic [AGE_W-1:0] right_age;

    if (i == 0) begin : g_first
      assign left_post = 1'b1;
    end else begin : g_mid
      assign left_post = post_w[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_value = '0;
      assign right_age   = '0;
    end else begin : g_inner
      assign right_valid = valid_w[i+1];
      assign right_value = value_w[i+1];
      assign right_age   = age_w[i+1];
    end

    swm_cell #(
      .VAL_W (VAL_W),
      .AGE_W (AGE_W)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctrl            (cell_ctrl),
      .sample          (sample),
      .left_post_valid (left_post),
      .right_valid     (right_valid),
      .right_value     (right_value),
      .right_age       (right_age),
      .valid           (valid_w[i]),
      .value           (value_w[i]),
      .age             (age_w[i]),
      .post_valid      (post_w[i]),
      .value_next      (next_w[i])
    );
  end

  assign front_next = next_w[0];

endmodule

FILE: rtl/sliding_window_minimum_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_minimum_unit
// Minimum over the most recent window_length samples, kept as a monotonic
// queue spread over a row of cells.
// ----------------------------------------------------------------------------
// a result is registered in the output register, or in the skid slot while the output stalls
// throughput: one request per cycle while the skid slot is empty; the whole cell row updates in one step
// a two-deep output stage lets one more request in while a result waits
// reset: queue empty, counters zero, window length 1; no clearing pass
// a window length write empties the queue like a restart
module sliding_window_minimum_unit #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  swm_cfg_if.sink             cfg,
  swm_stream_if.sink          stream,
  swm_result_if.source        result
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W = $clog2(WINDOW_MAX);

  logic [LEN_W-1:0]             len;
  logic [LEN_W-1:0]             len_next;
  logic [LEN_W-1:0]             seen;
  logic [LEN_W-1:0]             seen_next;
  logic [31:0]                  cfg_wide;
  logic                         cfg_fire;
  logic                         in_fire;
  logic                         emit;
  logic [SAMPLE_BITS-1:0]       front_next;
  logic [63:0]                  front_wide;
  logic [swm_pkg::OUT_BITS-1:0] res_value;
  logic                         out_valid;
  logic [swm_pkg::OUT_BITS-1:0] out_value;
  logic                         skid_valid;
  logic [swm_pkg::OUT_BITS-1:0] skid_value;
  swm_pkg::row_ctrl_t           row_ctrl;

  assign cfg.ready    = 1'b1;
  assign cfg_fire     = cfg.valid && cfg.ready;
  assign stream.ready = !skid_valid;
  assign in_fire      = stream.valid && stream.ready;

  // zero acts as one, oversize clamps to the row length
  always_comb begin
    cfg_wide = 32'(cfg.window_length);
    if (cfg_wide == 32'd0) begin
      len_next = LEN_W'(1);
    end else if (cfg_wide > 32'(WINDOW_MAX)) begin
      len_next = LEN_W'(WINDOW_MAX);
    end else begin
      len_next = LEN_W'(cfg_wide);
    end
  end

  always_comb begin
    if (stream.restart) begin
      seen_next = LEN_W'(1);
    end else if (seen == LEN_W'(WINDOW_MAX)) begin
      seen_next = seen;
    end else begin
      seen_next = seen + LEN_W'(1);
    end
  end

  assign emit = in_fire && (seen_next >= len);

  always_comb begin
    row_ctrl.clear   = cfg_fire;
    row_ctrl.step    = in_fire;
    row_ctrl.restart = stream.restart;
  end

  swm_row #(
    .WINDOW_MAX (WINDOW_MAX),
    .VAL_W      (SAMPLE_BITS),
    .LEN_W      (LEN_W),
    .AGE_W      (AGE_W)
  ) u_row (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (row_ctrl),
    .sample     (stream.sample),
    .len        (len),
    .front_next (front_next)
  );

  assign front_wide = 64'(front_next);
  assign res_value  = front_wide[swm_pkg::OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= LEN_W'(1);
      seen <= '0;
    end else if (cfg_fire) begin
      len  <= len_next;
      seen <= '0;
    end else if (in_fire) begin
      seen <= seen_next;
    end
  end

  // output register backed by one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_value <= skid_valid ? skid_value : res_value;
    end
    if (emit) begin
      skid_value <= res_value;
    end
  end

  assign result.valid      = out_valid;
  assign result.window_min = out_value;

endmodule

FILE: rtl/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the sliding window minimum unit.
// ----------------------------------------------------------------------------
module swm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [swm_pkg::OUT_BITS-1:0] out_window_min
);

  // input only stalls when both output slots hold results
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a pending stall releases once the result is taken
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    (!in_ready && out_ready) |=> in_ready)
    else $error("input still stalled after result taken");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("output not empty after reset");

  a_cfg_always_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("window length write refused");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_window_min)))
    else $error("stalled result changed");

endmodule

bind sliding_window_minimum_unit swm_checker u_swm_checker (
  .clk            (clk),
  .rst            (rst),
  .cfg_valid      (cfg.valid),
  .cfg_ready      (cfg.ready),
  .in_ready       (stream.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_window_min (result.window_min)
);
